// ===== hw/rtl/lge_pkg.sv =====
// Shared constants, types and helper functions of the Life generation engine.
package lge_pkg;

	localparam int MAX_ROWS = 32;
	localparam int MAX_COLS = 128;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int NR_W = $clog2(MAX_ROWS + 1);
	localparam int NC_W = $clog2(MAX_COLS + 1);
	localparam int CNT_W = 13;
	localparam int RROWS_W = 6;
	localparam int RCOLS_W = 8;
	localparam int CFG_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int ROWS_RESET = 20;
	localparam int COLS_RESET = 80;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

	localparam int CHUNK_W = 8;
	localparam int NCHUNK = (MAX_COLS + CHUNK_W - 1) / CHUNK_W;
	localparam int GRP_CHUNKS = 4;
	localparam int NGRP = (NCHUNK + GRP_CHUNKS - 1) / GRP_CHUNKS;
	localparam int PAD_W = NGRP * GRP_CHUNKS * CHUNK_W;
	localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);
	localparam int GRP_CNT_W = $clog2(GRP_CHUNKS * CHUNK_W + 1);

	typedef logic [MAX_COLS-1:0] row_bits_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_SET   = 2'd1,
		OP_GEN   = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_LIVE  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACCESS,
		S_GEN,
		S_DRAIN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic             en;
		logic [ROW_W-1:0] addr;
		row_bits_t        data;
	} mem_wr_t;

	typedef struct packed {
		logic            en;
		logic [NR_W-1:0] from;
	} row_clr_t;

	typedef struct packed {
		logic            en;
		logic [NR_W-1:0] idx;
	} gen_issue_t;

	function automatic logic [NR_W-1:0] clamp_rows(input logic [RROWS_W-1:0] v);
		if (v == '0) begin
			return NR_W'(1);
		end else if (int'(v) > MAX_ROWS) begin
			return NR_W'(MAX_ROWS);
		end else begin
			return NR_W'(v);
		end
	endfunction

	function automatic logic [NC_W-1:0] clamp_cols(input logic [RCOLS_W-1:0] v);
		if (v == '0) begin
			return NC_W'(1);
		end else if (int'(v) > MAX_COLS) begin
			return NC_W'(MAX_COLS);
		end else begin
			return NC_W'(v);
		end
	endfunction

	function automatic row_bits_t col_mask(input logic [NC_W-1:0] nc);
		row_bits_t m;
		for (int i = 0; i < MAX_COLS; i++) begin
			m[i] = (i < int'(nc));
		end
		return m;
	endfunction

	function automatic logic [CHUNK_CNT_W-1:0] popcnt_chunk(input logic [CHUNK_W-1:0] v);
		logic [CHUNK_CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			n = n + CHUNK_CNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

// ===== hw/rtl/lge_row_mem.sv =====
// Grid row memory with registered read and per-row valid flags.
module lge_row_mem
	import lge_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mem_rd_t   rd_req,
	input  mem_wr_t   wr_req,
	input  row_clr_t  clr_req,
	output row_bits_t rd_data,
	output logic      rd_row_valid
);

	row_bits_t            mem [MAX_ROWS];
	logic [MAX_ROWS-1:0]  row_valid_q;
	row_bits_t            rd_data_q;
	logic                 rd_row_valid_q;

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem[wr_req.addr] <= wr_req.data;
		end
		if (rd_req.en) begin
			rd_data_q <= mem[rd_req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_row_valid_q <= 1'b0;
		end else begin
			if (clr_req.en) begin
				for (int i = 0; i < MAX_ROWS; i++) begin
					if (i >= int'(clr_req.from)) begin
						row_valid_q[i] <= 1'b0;
					end
				end
			end
			if (wr_req.en) begin
				row_valid_q[wr_req.addr] <= 1'b1;
			end
			if (rd_req.en) begin
				rd_row_valid_q <= row_valid_q[rd_req.addr];
			end
		end
	end

	assign rd_data = rd_data_q;
	assign rd_row_valid = rd_row_valid_q;

endmodule

// ===== hw/rtl/lge_row_eval.sv =====
// Three-row window, next-generation rule per row, and pipelined population counts.
module lge_row_eval
	import lge_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  gen_issue_t       issue,
	input  logic [NR_W-1:0]  nr,
	input  row_bits_t        colmask,
	input  row_bits_t        rd_data,
	input  logic             rd_row_valid,
	output mem_wr_t          wr_req,
	output logic             busy,
	output logic [CNT_W-1:0] acc_live,
	output logic [CNT_W-1:0] acc_born,
	output logic [CNT_W-1:0] acc_died
);

	function automatic logic life_rule(input logic [2:0] up, input logic [2:0] mid,
		input logic [2:0] dn);
		logic [3:0] n;
		n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
			+ 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
		return (n == 4'd3) || (mid[1] && (n == 4'd2));
	endfunction

	logic                 s1_v_q;
	logic [NR_W-1:0]      s1_idx_q;
	logic                 s2_v_q;
	logic [ROW_W-1:0]     s2_idx_q;
	row_bits_t            above_s2;
	row_bits_t            cur_s2;
	row_bits_t            below_s2;
	logic                 s3_v_q;
	row_bits_t            next_s3;
	row_bits_t            born_s3;
	row_bits_t            died_s3;
	logic                 s4_v_q;
	logic [GRP_CNT_W-1:0] part_live_s4 [NGRP];
	logic [GRP_CNT_W-1:0] part_born_s4 [NGRP];
	logic [GRP_CNT_W-1:0] part_died_s4 [NGRP];
	logic [CNT_W-1:0]     acc_live_q;
	logic [CNT_W-1:0]     acc_born_q;
	logic [CNT_W-1:0]     acc_died_q;

	row_bits_t            in_row;
	row_bits_t            next_row;
	logic [MAX_COLS+1:0]  a_x;
	logic [MAX_COLS+1:0]  c_x;
	logic [MAX_COLS+1:0]  b_x;
	logic [PAD_W-1:0]     live_pad;
	logic [PAD_W-1:0]     born_pad;
	logic [PAD_W-1:0]     died_pad;
	logic [GRP_CNT_W-1:0] grp_live [NGRP];
	logic [GRP_CNT_W-1:0] grp_born [NGRP];
	logic [GRP_CNT_W-1:0] grp_died [NGRP];
	logic [CNT_W-1:0]     sum_live;
	logic [CNT_W-1:0]     sum_born;
	logic [CNT_W-1:0]     sum_died;

	assign in_row = ((s1_idx_q < nr) && rd_row_valid) ? (rd_data & colmask) : '0;

	assign a_x = {1'b0, above_s2, 1'b0};
	assign c_x = {1'b0, cur_s2, 1'b0};
	assign b_x = {1'b0, below_s2, 1'b0};

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			next_row[c] = colmask[c] & life_rule(a_x[c +: 3], c_x[c +: 3], b_x[c +: 3]);
		end
	end

	assign wr_req.en = s2_v_q;
	assign wr_req.addr = s2_idx_q;
	assign wr_req.data = next_row;

	assign live_pad = PAD_W'(next_s3);
	assign born_pad = PAD_W'(born_s3);
	assign died_pad = PAD_W'(died_s3);

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_live[g] = '0;
			grp_born[g] = '0;
			grp_died[g] = '0;
			for (int k = 0; k < GRP_CHUNKS; k++) begin
				grp_live[g] = grp_live[g]
					+ GRP_CNT_W'(popcnt_chunk(live_pad[(g*GRP_CHUNKS+k)*CHUNK_W +: CHUNK_W]));
				grp_born[g] = grp_born[g]
					+ GRP_CNT_W'(popcnt_chunk(born_pad[(g*GRP_CHUNKS+k)*CHUNK_W +: CHUNK_W]));
				grp_died[g] = grp_died[g]
					+ GRP_CNT_W'(popcnt_chunk(died_pad[(g*GRP_CHUNKS+k)*CHUNK_W +: CHUNK_W]));
			end
		end
	end

	always_comb begin
		sum_live = '0;
		sum_born = '0;
		sum_died = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum_live = sum_live + CNT_W'(part_live_s4[g]);
			sum_born = sum_born + CNT_W'(part_born_s4[g]);
			sum_died = sum_died + CNT_W'(part_died_s4[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (issue.en) begin
			s1_idx_q <= issue.idx;
		end
		if (start) begin
			above_s2 <= '0;
			cur_s2 <= '0;
			below_s2 <= '0;
		end else if (s1_v_q) begin
			above_s2 <= cur_s2;
			cur_s2 <= below_s2;
			below_s2 <= in_row;
			s2_idx_q <= ROW_W'(s1_idx_q - NR_W'(1));
		end
		if (s2_v_q) begin
			next_s3 <= next_row;
			born_s3 <= next_row & ~cur_s2;
			died_s3 <= cur_s2 & ~next_row;
		end
		if (s3_v_q) begin
			part_live_s4 <= grp_live;
			part_born_s4 <= grp_born;
			part_died_s4 <= grp_died;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
			s3_v_q <= 1'b0;
			s4_v_q <= 1'b0;
			acc_live_q <= '0;
			acc_born_q <= '0;
			acc_died_q <= '0;
		end else begin
			s1_v_q <= issue.en;
			s2_v_q <= s1_v_q && (s1_idx_q != '0);
			s3_v_q <= s2_v_q;
			s4_v_q <= s3_v_q;
			if (start) begin
				acc_live_q <= '0;
				acc_born_q <= '0;
				acc_died_q <= '0;
			end else if (s4_v_q) begin
				acc_live_q <= acc_live_q + sum_live;
				acc_born_q <= acc_born_q + sum_born;
				acc_died_q <= acc_died_q + sum_died;
			end
		end
	end

	assign busy = s1_v_q | s2_v_q | s3_v_q | s4_v_q;
	assign acc_live = acc_live_q;
	assign acc_born = acc_born_q;
	assign acc_died = acc_died_q;

endmodule

// ===== hw/rtl/life_generation_engine_core.sv =====
// Top level of the Life generation engine: command sequencer, counters and result register.
// Clear goes straight to the result state; set and read first pass through the memory access state.
// A generation reads one memory row per cycle for the rows in use plus one, then passes through
// the neighbor window, the population count pipeline, the count update and the result register.
// One transaction is in work at a time; a new one is taken while the last result waits.
// Reset clears the per-row valid flags so the grid reads as all dead at once, zeroes the
// counters and loads 20 rows by 80 columns; no clearing pass is needed.
module life_generation_engine_core
	import lge_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  logic [4:0]           row,
	input  logic [6:0]           column,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 cell_alive,
	output logic [1:0]           status,
	output logic [CNT_W-1:0]     live_count,
	output logic [CNT_W-1:0]     births,
	output logic [CNT_W-1:0]     deaths,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	state_t               state_q;
	state_t               state_d;
	logic [RROWS_W-1:0]   rows_q;
	logic [RCOLS_W-1:0]   cols_q;
	logic [CNT_W-1:0]     live_q;
	logic [CNT_W-1:0]     born_q;
	logic [CNT_W-1:0]     died_q;
	logic [NR_W-1:0]      gen_idx_q;
	op_t                  op_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic                 in_window_q;
	logic                 res_alive_q;
	stat_t                res_status_q;
	logic                 out_valid_q;
	logic                 out_alive_q;
	stat_t                out_status_q;
	logic [CNT_W-1:0]     out_live_q;
	logic [CNT_W-1:0]     out_born_q;
	logic [CNT_W-1:0]     out_died_q;

	logic [NR_W-1:0]      nr;
	logic [NC_W-1:0]      nc;
	row_bits_t            colmask;
	logic                 in_window;
	logic                 accept;
	mem_rd_t              rd_req;
	mem_wr_t              mem_wr;
	mem_wr_t              eval_wr;
	row_clr_t             clr_req;
	gen_issue_t           issue;
	logic                 gen_start;
	logic                 set_we;
	logic                 out_load;
	logic                 drain_done;
	row_bits_t            rd_data;
	logic                 rd_row_valid;
	logic                 bit_live;
	logic                 busy;
	logic [CNT_W-1:0]     acc_live;
	logic [CNT_W-1:0]     acc_born;
	logic [CNT_W-1:0]     acc_died;

	assign nr = clamp_rows(rows_q);
	assign nc = clamp_cols(cols_q);
	assign colmask = col_mask(nc);
	assign in_window = (NR_W'(row) < nr) && (NC_W'(column) < nc);
	assign accept = in_valid && in_ready;
	assign bit_live = rd_row_valid && rd_data[col_q];
	assign drain_done = (state_q == S_DRAIN) && !busy;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		rd_req = '0;
		issue = '0;
		clr_req = '0;
		gen_start = 1'b0;
		set_we = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op_t'(operation))
						OP_CLEAR: begin
							clr_req.en = 1'b1;
							state_d = S_RESP;
						end
						OP_GEN: begin
							gen_start = 1'b1;
							state_d = S_GEN;
						end
						OP_SET, OP_READ: begin
							rd_req.en = 1'b1;
							rd_req.addr = row;
							state_d = S_ACCESS;
						end
						default: state_d = S_RESP;
					endcase
				end
			end
			S_ACCESS: begin
				set_we = (op_q == OP_SET) && in_window_q && !bit_live;
				state_d = S_RESP;
			end
			S_GEN: begin
				issue.en = 1'b1;
				issue.idx = gen_idx_q;
				rd_req.en = 1'b1;
				rd_req.addr = gen_idx_q[ROW_W-1:0];
				if (gen_idx_q == nr) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!busy) begin
					clr_req.en = 1'b1;
					clr_req.from = nr;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		if (set_we) begin
			mem_wr.en = 1'b1;
			mem_wr.addr = row_q;
			mem_wr.data = (rd_row_valid ? rd_data : '0) | (row_bits_t'(1) << col_q);
		end else begin
			mem_wr = eval_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q <= RROWS_W'(ROWS_RESET);
			cols_q <= RCOLS_W'(COLS_RESET);
			live_q <= '0;
			born_q <= '0;
			died_q <= '0;
			gen_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: rows_q <= cfg_data[RROWS_W-1:0];
					REG_COLS: cols_q <= cfg_data[RCOLS_W-1:0];
					default: ;
				endcase
			end
			if (clr_req.en && (state_q == S_IDLE)) begin
				live_q <= '0;
				born_q <= '0;
				died_q <= '0;
			end else if (set_we) begin
				live_q <= live_q + CNT_W'(1);
			end else if (drain_done) begin
				live_q <= acc_live;
				born_q <= acc_born;
				died_q <= acc_died;
			end
			if (gen_start) begin
				gen_idx_q <= '0;
			end else if (state_q == S_GEN) begin
				gen_idx_q <= gen_idx_q + NR_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(operation);
			row_q <= row;
			col_q <= column;
			in_window_q <= in_window;
			res_alive_q <= 1'b0;
			res_status_q <= STAT_OK;
		end else if (state_q == S_ACCESS) begin
			if (!in_window_q) begin
				res_status_q <= STAT_RANGE;
			end else if (op_q == OP_READ) begin
				res_alive_q <= bit_live;
			end else if (bit_live) begin
				res_status_q <= STAT_LIVE;
			end
		end
		if (out_load) begin
			out_alive_q <= res_alive_q;
			out_status_q <= res_status_q;
			out_live_q <= live_q;
			out_born_q <= born_q;
			out_died_q <= died_q;
		end
	end

	lge_row_mem u_row_mem (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_req       (rd_req),
		.wr_req       (mem_wr),
		.clr_req      (clr_req),
		.rd_data      (rd_data),
		.rd_row_valid (rd_row_valid)
	);

	lge_row_eval u_row_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (gen_start),
		.issue        (issue),
		.nr           (nr),
		.colmask      (colmask),
		.rd_data      (rd_data),
		.rd_row_valid (rd_row_valid),
		.wr_req       (eval_wr),
		.busy         (busy),
		.acc_live     (acc_live),
		.acc_born     (acc_born),
		.acc_died     (acc_died)
	);

	assign out_valid = out_valid_q;
	assign cell_alive = out_alive_q;
	assign status = out_status_q;
	assign live_count = out_live_q;
	assign births = out_born_q;
	assign deaths = out_died_q;

	a_gen_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GEN) |-> (gen_idx_q <= nr))
		else $error("Generation row pointer ran past the rows in use.");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("Accepted transaction did not start any work.");

	a_drain_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |=> (state_q == S_RESP) && !busy)
		else $error("Generation finished without moving to the result state.");

	a_no_write_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr.en && clr_req.en))
		else $error("Row write collided with a valid flag clear.");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CNT_W'(MAX_ROWS * MAX_COLS))
		else $error("Live count exceeds the number of cells.");

endmodule

// ===== bench/life_generation_engine_core_test.sv =====
// Self-checking testbench of the Life generation engine core: driven commands, predicted results.
module life_generation_engine_core_test;
	import lge_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_PHASE = 2;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		op_t        op;
		logic [4:0] r;
		logic [6:0] c;
	} life_cmd_t;

	typedef struct packed {
		logic             alive;
		stat_t            status;
		logic [CNT_W-1:0] live;
		logic [CNT_W-1:0] born;
		logic [CNT_W-1:0] died;
	} life_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           operation = '0;
	logic [4:0]           row = '0;
	logic [6:0]           column = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 cell_alive;
	logic [1:0]           status;
	logic [CNT_W-1:0]     live_count;
	logic [CNT_W-1:0]     births;
	logic [CNT_W-1:0]     deaths;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	life_cmd_t    cmd_queue[$];
	life_result_t expected_results[$];
	int           error_count = 0;
	int           phase_idx = 0;
	int           send_idle_pct = 36;
	int           recv_idle_pct = 46;

	logic [RROWS_W-1:0] rows_reg = RROWS_W'(ROWS_RESET);
	logic [RCOLS_W-1:0] cols_reg = RCOLS_W'(COLS_RESET);
	logic [MAX_COLS-1:0] board [MAX_ROWS];
	int                 board_live = 0;
	int                 gen_births = 0;
	int                 gen_deaths = 0;

	life_generation_engine_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.row        (row),
		.column     (column),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cell_alive (cell_alive),
		.status     (status),
		.live_count (live_count),
		.births     (births),
		.deaths     (deaths),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int window_rows();
		if (rows_reg == '0) begin
			return 1;
		end
		return (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic int window_cols();
		if (cols_reg == '0) begin
			return 1;
		end
		return (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
	endfunction

	// Applies one command to the mirrored grid and returns the result it must produce.
	function automatic life_result_t predict_life_step(op_t op, logic [4:0] r, logic [6:0] c);
		life_result_t        res;
		logic [MAX_COLS-1:0] next_board [MAX_ROWS];
		int                  nr;
		int                  nc;
		int                  n;
		int                  born;
		int                  died;
		int                  alive_cnt;
		logic                nxt;
		logic                in_window;
		nr = window_rows();
		nc = window_cols();
		res.alive = 1'b0;
		res.status = STAT_OK;
		in_window = (int'(r) < nr) && (int'(c) < nc);
		case (op)
			OP_CLEAR: begin
				for (int i = 0; i < MAX_ROWS; i++) begin
					board[i] = '0;
				end
				board_live = 0;
				gen_births = 0;
				gen_deaths = 0;
			end
			OP_SET: begin
				if (!in_window) begin
					res.status = STAT_RANGE;
				end else if (board[r][c]) begin
					res.status = STAT_LIVE;
				end else begin
					board[r][c] = 1'b1;
					board_live++;
				end
			end
			OP_GEN: begin
				born = 0;
				died = 0;
				alive_cnt = 0;
				for (int i = 0; i < MAX_ROWS; i++) begin
					next_board[i] = '0;
				end
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						n = 0;
						for (int di = -1; di <= 1; di++) begin
							for (int dj = -1; dj <= 1; dj++) begin
								if ((di != 0 || dj != 0) && i + di >= 0 && i + di < nr &&
										j + dj >= 0 && j + dj < nc) begin
									n += board[i + di][j + dj];
								end
							end
						end
						nxt = (n == 3) || (board[i][j] && n == 2);
						next_board[i][j] = nxt;
						if (nxt && !board[i][j]) born++;
						if (!nxt && board[i][j]) died++;
						if (nxt) alive_cnt++;
					end
				end
				board = next_board;
				board_live = alive_cnt;
				gen_births = born;
				gen_deaths = died;
			end
			default: begin
				if (!in_window) begin
					res.status = STAT_RANGE;
				end else begin
					res.alive = board[r][c];
				end
			end
		endcase
		res.live = CNT_W'(board_live);
		res.born = CNT_W'(gen_births);
		res.died = CNT_W'(gen_deaths);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg <= RROWS_W'(ROWS_RESET);
			cols_reg <= RCOLS_W'(COLS_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS: rows_reg <= cfg_data[RROWS_W-1:0];
				REG_COLS: cols_reg <= cfg_data[RCOLS_W-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin : command_driver
		life_cmd_t next_cmd;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_life_step(op_t'(operation), row, column));
			end
			if (!in_valid || in_ready) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = cmd_queue.pop_front();
					in_valid <= 1'b1;
					operation <= next_cmd.op;
					row <= next_cmd.r;
					column <= next_cmd.c;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_receiver
		int  hold_left;
		bit  hold_taken;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			hold_taken = 1'b0;
		end else if (phase_idx == HOLD_PHASE && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		life_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				if (error_count < 10) begin
					$display("unexpected result transaction: alive %0d status %0d live %0d",
						cell_alive, status, live_count);
				end
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (cell_alive !== want.alive || status !== want.status ||
						live_count !== want.live || births !== want.born ||
						deaths !== want.died) begin
					if (error_count < 10) begin
						$display({"mismatch (expected/actual): alive %0d/%0d status %0d/%0d ",
							"live %0d/%0d births %0d/%0d deaths %0d/%0d"},
							want.alive, cell_alive, want.status, status, want.live, live_count,
							want.born, births, want.died, deaths);
					end
					error_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb: failure");
		$finish;
	end

	task automatic push_cmd(op_t op, int r, int c);
		life_cmd_t cmd;
		cmd.op = op;
		cmd.r = 5'(r);
		cmd.c = 7'(c);
		cmd_queue.push_back(cmd);
	endtask

	task automatic wait_drained();
		while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Mostly builds and evolves patterns inside the window; some commands land anywhere.
	task automatic push_random_cmds(int count);
		int nr;
		int nc;
		int pick;
		nr = window_rows();
		nc = window_cols();
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				push_cmd(OP_SET, $urandom_range(nr - 1), $urandom_range(nc - 1));
			end else if (pick < 62) begin
				push_cmd(OP_GEN, $urandom_range(31), $urandom_range(127));
			end else if (pick < 82) begin
				push_cmd(OP_READ, $urandom_range(nr - 1), $urandom_range(nc - 1));
			end else if (pick < 92) begin
				push_cmd($urandom_range(1) ? OP_SET : OP_READ, $urandom_range(31),
					$urandom_range(127));
			end else if (pick < 94) begin
				push_cmd(OP_CLEAR, $urandom_range(31), $urandom_range(127));
			end else begin
				push_cmd($urandom_range(1) ? OP_SET : OP_READ,
					$urandom_range(1) ? nr - 1 : (nr > 31 ? 31 : nr),
					$urandom_range(1) ? nc - 1 : (nc > 127 ? 127 : nc));
			end
		end
	endtask

	task automatic run_phase(int rows_v, int cols_v, int count, int send_pct, int recv_pct);
		@(posedge clk);
		phase_idx <= phase_idx + 1;
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS;
		cfg_data <= CFG_W'(rows_v);
		@(posedge clk);
		cfg_index <= REG_COLS;
		cfg_data <= CFG_W'(cols_v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		push_random_cmds(count / 2);
		wait_drained();
		push_random_cmds(count - count / 2);
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < MAX_ROWS; i++) begin
			board[i] = '0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window of 20 rows by 80 columns: corners, range errors and small patterns.
		push_cmd(OP_READ, 0, 0);
		push_cmd(OP_SET, 0, 0);
		push_cmd(OP_SET, 0, 0);
		push_cmd(OP_SET, 19, 79);
		push_cmd(OP_READ, 19, 79);
		push_cmd(OP_SET, 20, 0);
		push_cmd(OP_SET, 0, 80);
		push_cmd(OP_READ, 31, 127);
		push_cmd(OP_SET, 31, 127);
		push_cmd(OP_SET, 10, 40);
		push_cmd(OP_SET, 10, 41);
		push_cmd(OP_SET, 10, 42);
		push_cmd(OP_GEN, 0, 0);
		push_cmd(OP_READ, 9, 41);
		push_cmd(OP_READ, 10, 40);
		push_cmd(OP_GEN, 31, 127);
		push_cmd(OP_SET, 0, 0);
		push_cmd(OP_SET, 0, 1);
		push_cmd(OP_SET, 1, 0);
		push_cmd(OP_SET, 1, 1);
		push_cmd(OP_GEN, 0, 0);
		push_cmd(OP_CLEAR, 31, 127);
		push_cmd(OP_READ, 10, 41);
		push_cmd(OP_GEN, 0, 0);
		wait_drained();

		run_phase(8, 10, 90, 36, 46);
		run_phase(63, 255, 90, 36, 46);
		run_phase(3, 3, 60, 36, 46);
		run_phase(32, 128, 90, 46, 36);
		run_phase(0, 0, 30, 46, 36);
		run_phase(1, 128, 60, 46, 36);
		run_phase(32, 1, 60, 46, 36);
		run_phase(33, 129, 60, 0, 0);
		run_phase(5, 7, 90, 0, 0);
		run_phase(16, 64, 90, 0, 0);
		run_phase(20, 80, 60, 0, 0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lge_pkg.sv
hw/rtl/lge_row_mem.sv
hw/rtl/lge_row_eval.sv
hw/rtl/life_generation_engine_core.sv
bench/life_generation_engine_core_test.sv
